@@ hw/rtl/sfgm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgm_pkg
// Shared types and constants for the state-feedback gain multiply block.
// ----------------------------------------------------------------------------
package sfgm_pkg;

    localparam int SFGM_MAX_STATES  = 8;
    localparam int SFGM_MAX_OUTPUTS = 8;
    localparam int RESULT_CAP       = 8;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 3;
    localparam int VALUE_W = 16;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int ACC_W   = 40;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int FRAC_DROP = 12;

    // input item selector codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD_GAIN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_STATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUTPUTS = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic             clear_step;
        logic             load_gain;
        logic             set_state;
        logic             issue;
        logic [IDX_W-1:0] row;
        logic [CFG_W-1:0] col;
        logic             finalize;
        logic             last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic pipe_empty;
    } dp_status_t;

endpackage

@@ hw/rtl/sfgm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/sfgm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgm_datapath
// Gain RAM, state vector, MAC pipeline and rounded/saturated output register.
// ----------------------------------------------------------------------------
module sfgm_datapath
    import sfgm_pkg::*;
#(
    parameter int MAX_STATES  = SFGM_MAX_STATES,
    parameter int MAX_OUTPUTS = SFGM_MAX_OUTPUTS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic [IDX_W-1:0]          s_row,
    input  logic [IDX_W-1:0]          s_col,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic [IDX_W-1:0]          m_out_index,
    output logic signed [VALUE_W-1:0] m_out_value,
    output logic                      m_saturated,
    output logic                      m_last
);

    localparam int GT_DEPTH = MAX_OUTPUTS * MAX_STATES;
    localparam int GT_AW    = (GT_DEPTH > 1) ? $clog2(GT_DEPTH) : 1;
    localparam int SV_AW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;

    // clear sweep and RAM ports
    logic [GT_AW-1:0]   clr_cnt_reg;
    logic               ram_we;
    logic [GT_AW-1:0]   ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [GT_AW-1:0]   ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic signed [VALUE_W-1:0] state_vec_reg [MAX_STATES];

    // MAC pipeline
    logic                      v1_reg, v2_reg;
    logic                      f1_reg, f2_reg;
    logic signed [VALUE_W-1:0] x1_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    // finalize
    logic signed [ACC_W-1:0]   rnd_sum;
    logic signed [ACC_W-1:0]   rnd_q;
    logic signed [VALUE_W-1:0] sat_val;
    logic                      sat_flag;

    logic [IDX_W-1:0]          out_index_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_sat_reg;
    logic                      out_last_reg;

    always_comb begin
        ram_we    = cmd.clear_step | cmd.load_gain;
        ram_waddr = cmd.clear_step ? clr_cnt_reg : GT_AW'(s_row * MAX_STATES + s_col);
        ram_wdata = cmd.clear_step ? '0 : s_value;
        ram_raddr = GT_AW'(cmd.row * MAX_STATES + cmd.col);
    end

    sfgm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (GT_DEPTH),
        .AW    (GT_AW)
    ) u_gain_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + GT_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_STATES; k++) begin
                state_vec_reg[k] <= '0;
            end
        end else if (cmd.set_state) begin
            state_vec_reg[SV_AW'(s_col)] <= s_value;
        end
    end

    // issue -> RAM read / state fetch -> multiply -> accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        x1_reg   <= state_vec_reg[SV_AW'(cmd.col)];
        f1_reg   <= (cmd.col == '0);
        prod_reg <= $signed(ram_rdata) * x1_reg;
        f2_reg   <= f1_reg;
        if (v2_reg) begin
            acc_reg <= (f2_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        end
    end

    // negate, round half up to Q8.8, saturate
    always_comb begin
        rnd_sum = ACC_W'(2048) - acc_reg;
        rnd_q   = rnd_sum >>> FRAC_DROP;
        if (rnd_q > ACC_W'(32767)) begin
            sat_val  = 16'sh7FFF;
            sat_flag = 1'b1;
        end else if (rnd_q < -ACC_W'(32768)) begin
            sat_val  = 16'sh8000;
            sat_flag = 1'b1;
        end else begin
            sat_val  = rnd_q[VALUE_W-1:0];
            sat_flag = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finalize) begin
            out_index_reg <= cmd.row;
            out_value_reg <= sat_val;
            out_sat_reg   <= sat_flag;
            out_last_reg  <= cmd.last;
        end
    end

    assign status.clear_last = (clr_cnt_reg == GT_AW'(GT_DEPTH - 1));
    assign status.pipe_empty = ~v1_reg & ~v2_reg;

    assign m_out_index = out_index_reg;
    assign m_out_value = out_value_reg;
    assign m_saturated = out_sat_reg;
    assign m_last      = out_last_reg;

endmodule

@@ hw/rtl/sfgm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfgm_ctrl
// Sequencer: RAM clear sweep, item decode, row/column walk, output handshake.
// ----------------------------------------------------------------------------
module sfgm_ctrl
    import sfgm_pkg::*;
#(
    parameter int MAX_STATES  = SFGM_MAX_STATES,
    parameter int MAX_OUTPUTS = SFGM_MAX_OUTPUTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FUNC_W-1:0]    s_func,
    input  logic [IDX_W-1:0]     s_row,
    input  logic [IDX_W-1:0]     s_col,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dp_cmd_t              cmd,
    input  dp_status_t           status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] num_states_reg, num_outputs_reg;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [CFG_W-1:0] j_reg, j_next;
    logic             m_valid_reg, m_valid_next;

    logic [CFG_W-1:0] ns, no;
    logic             accept;
    logic             row_last;

    // clamp register values to usable counts
    always_comb begin
        if (num_states_reg == '0) begin
            ns = CFG_W'(1);
        end else if (num_states_reg > MAX_STATES) begin
            ns = CFG_W'(MAX_STATES);
        end else begin
            ns = num_states_reg;
        end
        if (num_outputs_reg == '0) begin
            no = CFG_W'(1);
        end else if (num_outputs_reg > MAX_OUTPUTS) begin
            no = CFG_W'(MAX_OUTPUTS);
        end else begin
            no = num_outputs_reg;
        end
        if (no > RESULT_CAP) begin
            no = CFG_W'(RESULT_CAP);
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign row_last = ({1'b0, i_reg} == no - CFG_W'(1));

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.row      = i_reg;
        cmd.col      = j_reg;
        cmd.last     = row_last;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_gain = (s_func == FUNC_LOAD_GAIN) &&
                                    (s_row < MAX_OUTPUTS) && (s_col < MAX_STATES);
                    cmd.set_state = (s_func == FUNC_SET_STATE) && ({1'b0, s_col} < ns);
                    if (s_func == FUNC_COMPUTE) begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (j_reg == ns - CFG_W'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + CFG_W'(1);
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty) begin
                    cmd.finalize = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (row_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next     = i_reg + IDX_W'(1);
                        j_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            m_valid_reg     <= 1'b0;
            i_reg           <= '0;
            j_reg           <= '0;
            num_states_reg  <= CFG_W'(1);
            num_outputs_reg <= CFG_W'(1);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_NUM_STATES:  num_states_reg  <= cfg_wr_data;
                    CFG_NUM_OUTPUTS: num_outputs_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hw/rtl/state_feedback_gain_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_feedback_gain_multiply
// Computes u = -K*x with one multiply-accumulate unit over a gain RAM.
// ----------------------------------------------------------------------------
// Gain loads and state sets produce no result.
// Compute request: per active row ns MAC issues, a drain until the MAC
//   pipeline is empty and a finalize, then the result waits for m_ready;
//   s_ready stays low until the last row's result has been taken.
// Reset: gains are cleared by a sweep over all MAX_OUTPUTS * MAX_STATES
//   entries (64 at defaults) with s_ready low; state vector clears at once, counts reset to one.
// ----------------------------------------------------------------------------
module state_feedback_gain_multiply
    import sfgm_pkg::*;
#(
    parameter int MAX_STATES  = SFGM_MAX_STATES,
    parameter int MAX_OUTPUTS = SFGM_MAX_OUTPUTS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_wr_data,
    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [FUNC_W-1:0]         s_func,
    input  logic [IDX_W-1:0]          s_row,
    input  logic [IDX_W-1:0]          s_col,
    input  logic signed [VALUE_W-1:0] s_value,
    // result items
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [IDX_W-1:0]          m_out_index,
    output logic signed [VALUE_W-1:0] m_out_value,
    output logic                      m_saturated,
    output logic                      m_last
);

    // The controller decides every transfer; the datapath only acts on
    // its command word and reports clear-sweep end and pipeline occupancy.
    dp_cmd_t    cmd;
    dp_status_t status;

    sfgm_ctrl #(
        .MAX_STATES  (MAX_STATES),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_row       (s_row),
        .s_col       (s_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    // Gain RAM (registered read), state registers, 3-stage MAC and the
    // round/saturate output register. Out-of-range loads are filtered in
    // the controller before they reach the write ports.
    sfgm_datapath #(
        .MAX_STATES  (MAX_STATES),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_value     (s_value),
        .m_out_index (m_out_index),
        .m_out_value (m_out_value),
        .m_saturated (m_saturated),
        .m_last      (m_last)
    );

endmodule

@@ dv/state_feedback_gain_multiply_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_feedback_gain_multiply_test
// Self-checking bench for the u = -K*x block. A queue-fed driver offers gain
// loads, state sets and compute requests. A shadow copy of the gain table,
// the state vector and both counts predicts every control output. A monitor
// checks each result transfer, field by field, in order.
// ----------------------------------------------------------------------------
module state_feedback_gain_multiply_test;
    import sfgm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SWEEP_WAIT    = 100;    // waits out the gain clear sweep after reset
    localparam int SETTLE_CYCLES = 20;     // margin for a trailing load to finish
    localparam int TAIL_CYCLES   = 200;
    localparam int LONG_HOLD     = 600;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int MAX_GAP       = 14;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_PHASE    = 2;

    // the one selector code the package leaves unnamed; the block drops it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]         func;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
        int unsigned               gap;    // idle cycles before this item is offered
    } feedback_item_t;

    typedef struct {
        logic [IDX_W-1:0]          out_index;
        logic signed [VALUE_W-1:0] out_value;
        logic                      saturated;
        logic                      last;
    } control_output_t;

    // ------------------------------------------------------------------------
    // DUT ports, all inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index   = '0;
    logic [CFG_W-1:0]          cfg_wr_data = '0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic [FUNC_W-1:0]         s_func      = '0;
    logic [IDX_W-1:0]          s_row       = '0;
    logic [IDX_W-1:0]          s_col       = '0;
    logic signed [VALUE_W-1:0] s_value     = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic [IDX_W-1:0]          m_out_index;
    logic signed [VALUE_W-1:0] m_out_value;
    logic                      m_saturated;
    logic                      m_last;

    state_feedback_gain_multiply u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_index (m_out_index),
        .m_out_value (m_out_value),
        .m_saturated (m_saturated),
        .m_last      (m_last)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow state of the block and the outputs it owes
    // ------------------------------------------------------------------------
    logic signed [VALUE_W-1:0] gain_model  [SFGM_MAX_OUTPUTS][SFGM_MAX_STATES];
    logic signed [VALUE_W-1:0] state_model [SFGM_MAX_STATES];
    logic [CFG_W-1:0]          ns_setting = 4'd1;
    logic [CFG_W-1:0]          no_setting = 4'd1;

    feedback_item_t  pending_items[$];
    control_output_t expected_outputs[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // receiver pacing, set from the sequence, read by the receiver
    bit rx_fast    = 1'b0;
    int hold_token = 0;

    // register value -> count in use: zero reads as one, large values clip
    function automatic int unsigned active_count(input logic [CFG_W-1:0] v,
                                                 input int unsigned maxv);
        if (v == '0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    // one request: per active row, -(sum K*x) rounded Q12.20 -> Q8.8 and clipped
    task automatic predict_control_outputs();
        int unsigned     n_cols;
        int unsigned     n_rows;
        int unsigned     i;
        int unsigned     j;
        longint          acc;
        longint          rounded;
        control_output_t res;
        n_cols = active_count(ns_setting, SFGM_MAX_STATES);
        n_rows = active_count(no_setting, SFGM_MAX_OUTPUTS);
        if (n_rows > RESULT_CAP)
            n_rows = RESULT_CAP;
        for (i = 0; i < n_rows; i++) begin
            acc = 0;
            for (j = 0; j < n_cols; j++)
                acc += longint'(gain_model[i][j]) * longint'(state_model[j]);
            // add half an LSB, floor: ties go toward plus infinity
            rounded = (-acc + (longint'(1) << (FRAC_DROP - 1))) >>> FRAC_DROP;
            res.saturated = 1'b0;
            if (rounded > 32767) begin
                rounded = 32767;
                res.saturated = 1'b1;
            end else if (rounded < -32768) begin
                rounded = -32768;
                res.saturated = 1'b1;
            end
            res.out_index = IDX_W'(i);
            res.out_value = VALUE_W'(rounded);
            res.last      = (i + 1 == n_rows);
            expected_outputs.insert(expected_outputs.size(), res);
        end
    endtask

    // update the shadow copy for one accepted input transfer
    task automatic track_item(input feedback_item_t it);
        case (it.func)
            FUNC_LOAD_GAIN: begin
                gain_model[it.row][it.col] = it.value;
            end
            FUNC_SET_STATE: begin
                // an index past the active state count is dropped
                if (it.col < active_count(ns_setting, SFGM_MAX_STATES))
                    state_model[it.col] = it.value;
            end
            FUNC_COMPUTE: begin
                predict_control_outputs();
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: pops the pending queue, waits each item's gap, holds valid and
    // payload until the transfer. On the transfer edge the next item can be
    // raised at once, so valid gets a single assignment per edge.
    // ------------------------------------------------------------------------
    feedback_item_t current_item;
    bit             offering   = 1'b0;
    bit             gap_loaded = 1'b0;
    int unsigned    gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            offering   = 1'b0;
            gap_loaded = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_item(current_item);
                offering = 1'b0;
            end
            if (!offering && pending_items.size() > 0) begin
                if (!gap_loaded) begin
                    gap_left   = pending_items[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    current_item = pending_items.pop_front();
                    gap_loaded   = 1'b0;
                    offering     = 1'b1;
                    s_func  <= current_item.func;
                    s_row   <= current_item.row;
                    s_col   <= current_item.col;
                    s_value <= current_item.value;
                end
            end
            s_valid <= offering;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random wait after each result transfer unless rx_fast, plus a long hold-off
    // started whenever the sequence bumps hold_token.
    // ------------------------------------------------------------------------
    int unsigned ready_wait = 0;
    int unsigned hold_left  = 0;
    int          hold_seen  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (m_valid && m_ready)
                ready_wait = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (ready_wait > 0) begin
                ready_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every result transfer against the oldest expected output
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        control_output_t got;
        control_output_t want;
        if (aresetn && m_valid && m_ready) begin
            got.out_index = m_out_index;
            got.out_value = m_out_value;
            got.saturated = m_saturated;
            got.last      = m_last;
            if (expected_outputs.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: index %0d value %0d sat %0b last %0b",
                             got.out_index, got.out_value, got.saturated, got.last);
            end else begin
                want = expected_outputs.pop_front();
                if (got.out_index !== want.out_index || got.out_value !== want.out_value ||
                    got.saturated !== want.saturated || got.last !== want.last) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"mismatch: index exp %0d got %0d, value exp %0d got %0d, ",
                                  "sat exp %0b got %0b, last exp %0b got %0b"},
                                 want.out_index, got.out_index, want.out_value,
                                 got.out_value, want.saturated, got.saturated,
                                 want.last, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------------
    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_outputs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic signed [VALUE_W-1:0] value, input bit fast);
        feedback_item_t it;
        it.func  = func;
        it.row   = row;
        it.col   = col;
        it.value = value;
        it.gap   = fast ? 0 : $urandom_range(0, MAX_GAP);
        pending_items.insert(pending_items.size(), it);
    endtask

    // wait until every item is through and every output has come, then let
    // a trailing load finish before touching the registers
    task automatic settle();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_outputs.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_NUM_STATES:  ns_setting = data;
            CFG_NUM_OUTPUTS: no_setting = data;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // mostly the edges of the legal range plus the out-of-range ones
    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 5))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return CFG_W'(SFGM_MAX_STATES);
            3:       return 4'd15;
            default: return CFG_W'($urandom_range(0, 15));
        endcase
    endfunction

    // extremes, small values that stay clear of clipping, or anything
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            1, 2:    return VALUE_W'(int'($urandom_range(0, 1023)) - 512);
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // mostly well-formed traffic inside the active region, some noise
    task automatic push_random_item(input int unsigned n_cols, input int unsigned n_rows,
                                    input bit fast, inout int unsigned made);
        int unsigned         sel;
        logic [FUNC_W-1:0]   func;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        sel  = $urandom_range(0, 99);
        row  = IDX_W'($urandom_range(0, 7));
        col  = IDX_W'($urandom_range(0, 7));
        if (sel < 35) begin
            func = FUNC_LOAD_GAIN;
            if ($urandom_range(0, 4) != 0) begin
                row = IDX_W'($urandom_range(0, n_rows - 1));
                col = IDX_W'($urandom_range(0, n_cols - 1));
            end
        end else if (sel < 75) begin
            func = FUNC_SET_STATE;
            if ($urandom_range(0, 5) != 0)
                col = IDX_W'($urandom_range(0, n_cols - 1));
        end else if (sel < 95) begin
            func = FUNC_COMPUTE;
        end else begin
            func = FUNC_UNUSED;
        end
        push_item(func, row, col, pick_value(), fast);
        if (func != FUNC_UNUSED)
            made++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned random_made;
        int unsigned phase;
        int unsigned n_cols;
        int unsigned n_rows;
        int unsigned r;
        int unsigned c;
        bit          fast;

        for (r = 0; r < SFGM_MAX_OUTPUTS; r++)
            for (c = 0; c < SFGM_MAX_STATES; c++)
                gain_model[r][c] = '0;
        for (c = 0; c < SFGM_MAX_STATES; c++)
            state_model[c] = '0;

        // single reset, then let the gain clear sweep run out
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SWEEP_WAIT) @(posedge aclk);
        @(negedge aclk);

        // null system after reset: 1x1 with zero gain, the set at index 1 is
        // past the state count and dropped
        push_item(FUNC_SET_STATE, 3'd0, 3'd0, 16'sh1234, 1'b0);
        push_item(FUNC_SET_STATE, 3'd7, 3'd1, 16'sh7FFF, 1'b0);
        push_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000, 1'b0);
        settle();

        // full 8x8: clipping both ways, rounding ties, unit gain
        write_cfg(CFG_NUM_STATES, 4'd8);
        write_cfg(CFG_NUM_OUTPUTS, 4'd8);
        push_item(FUNC_LOAD_GAIN, 3'd0, 3'd0, 16'sh7FFF, 1'b1);
        push_item(FUNC_LOAD_GAIN, 3'd7, 3'd7, 16'sh8000, 1'b1);
        push_item(FUNC_LOAD_GAIN, 3'd1, 3'd0, 16'sh8000, 1'b0);
        push_item(FUNC_LOAD_GAIN, 3'd2, 3'd1, 16'sh0001, 1'b0);
        push_item(FUNC_LOAD_GAIN, 3'd3, 3'd2, 16'sh1000, 1'b0);
        push_item(FUNC_SET_STATE, 3'd5, 3'd0, 16'sh7FFF, 1'b0);
        push_item(FUNC_SET_STATE, 3'd0, 3'd7, 16'sh8000, 1'b0);
        push_item(FUNC_SET_STATE, 3'd0, 3'd1, -16'sd2048, 1'b0);  // +half LSB tie
        push_item(FUNC_SET_STATE, 3'd0, 3'd2, 16'sh0100, 1'b0);
        push_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000, 1'b0);
        push_item(FUNC_SET_STATE, 3'd0, 3'd1, 16'sd2048, 1'b0);   // -half LSB tie
        push_item(FUNC_UNUSED, 3'd7, 3'd7, 16'shFFFF, 1'b0);
        push_item(FUNC_COMPUTE, 3'd7, 3'd7, 16'shFFFF, 1'b1);
        settle();

        // three states, outputs register above the maximum
        write_cfg(CFG_NUM_STATES, 4'd3);
        write_cfg(CFG_NUM_OUTPUTS, 4'd15);
        push_item(FUNC_SET_STATE, 3'd0, 3'd5, 16'sd100, 1'b0);     // past count, dropped
        push_item(FUNC_SET_STATE, 3'd0, 3'd2, -16'sd1, 1'b0);
        push_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000, 1'b0);
        settle();

        // both registers zero: used as one
        write_cfg(CFG_NUM_STATES, 4'd0);
        write_cfg(CFG_NUM_OUTPUTS, 4'd0);
        push_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000, 1'b0);
        settle();

        // states register above the maximum, element 5 must still be zero
        write_cfg(CFG_NUM_STATES, 4'd9);
        write_cfg(CFG_NUM_OUTPUTS, 4'd2);
        push_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000, 1'b0);

        // random phases, each under fresh register settings
        random_made = 0;
        phase = 0;
        while (random_made < RANDOM_ITEMS) begin
            settle();
            write_cfg(CFG_NUM_STATES, pick_setting());
            write_cfg(CFG_NUM_OUTPUTS, pick_setting());
            n_cols = active_count(ns_setting, SFGM_MAX_STATES);
            n_rows = active_count(no_setting, SFGM_MAX_OUTPUTS);
            fast = ($urandom_range(0, 3) == 0);
            rx_fast <= ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE) begin
                // receiver stalls long while the sender keeps requests coming,
                // so the block backs up and drops s_ready
                hold_token <= hold_token + 1;
                fast = 1'b1;
                for (r = 0; r < 8; r++)
                    push_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000, 1'b1);
                random_made += 8;
            end
            repeat ($urandom_range(12, 36))
                push_random_item(n_cols, n_rows, fast, random_made);
            phase++;
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_outputs.size() != 0) begin
            $display("%0d expected results never arrived", expected_outputs.size());
            error_count += expected_outputs.size();
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sfgm_pkg.sv
hw/rtl/sfgm_ram.sv
hw/rtl/sfgm_datapath.sv
hw/rtl/sfgm_ctrl.sv
hw/rtl/state_feedback_gain_multiply.sv
dv/state_feedback_gain_multiply_test.sv
